// ----- sv/ellpack_tile_vector_gather_core_assert.svh -----
// Assertion macros for the gather core. Each expects clk and arst_n in scope.
`ifndef ELLPACK_TILE_VECTOR_GATHER_CORE_ASSERT_SVH
`define ELLPACK_TILE_VECTOR_GATHER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ETVG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETVG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold later than for ETVG_ASSERT_NEXT.
`define ETVG_ASSERT_LATER(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> ##1 (cons)) \
		else $error(msg);

`endif

// ----- sv/etvg_pkg.sv -----
`timescale 1ns / 1ps

package etvg_pkg;

	localparam int TILE_DIM    = 32;
	localparam int POS_W       = 10;
	localparam int COL_W       = 5;
	localparam int FACE_W      = 4;
	localparam int DATA_W      = 32;
	localparam int SIZE_W      = 11;
	localparam int CFG_INDEX_W = 2;

	localparam logic [DATA_W-1:0] SENTINEL = '1;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_GATHER = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_OFFSET = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_SIZE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FACE_LAYOUT  = 2'd2;

	localparam logic [DATA_W-1:0] CHUNK_OFFSET_RESET = '0;
	localparam logic [SIZE_W-1:0] CHUNK_SIZE_RESET   = 11'd1024;
	localparam logic              FACE_LAYOUT_RESET  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load_wr;
		logic capture;
		logic lookup;
		logic respond;
	} cmd_t;

	// Tile position is row-major {row, col}; face layout reorders the bits
	// to {row msb, col msb, row low bits, col low bits}.
	function automatic logic [POS_W-1:0] dest_of(input logic [POS_W-1:0] pos,
		input logic face);
		logic [COL_W-1:0] row;
		logic [COL_W-1:0] col;
		row = pos[POS_W-1:COL_W];
		col = pos[COL_W-1:0];
		if (face)
			return {row[COL_W-1], col[COL_W-1], row[FACE_W-1:0], col[FACE_W-1:0]};
		return pos;
	endfunction

endpackage

// ----- sv/ellpack_tile_vector_gather_core.sv -----
`timescale 1ns / 1ps
// Load: busy stays low, so the next item may follow at once.
// Gather: the controller goes through LOOKUP, then RESP, where done strobes the
// result; busy is high in both, so the next item waits (store read is registered).
// arst_n resets the controller, tile position, row flag and config registers;
// the vector store is not cleared. The receiver cannot stall the result.
module ellpack_tile_vector_gather_core #(
	parameter int CHUNK_WORDS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             opcode,
	input  logic [etvg_pkg::DATA_W-1:0]      index,
	input  logic [etvg_pkg::DATA_W-1:0]      word,
	output logic                             done,
	output logic [etvg_pkg::POS_W-1:0]       dest_slot,
	output logic                             write_enable,
	output logic [etvg_pkg::DATA_W-1:0]      value,
	input  logic                             cfg_write,
	input  logic [etvg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [etvg_pkg::DATA_W-1:0]      cfg_data
);

	`include "ellpack_tile_vector_gather_core_assert.svh"

	etvg_pkg::cmd_t cmd;

	etvg_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(opcode),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	etvg_datapath #(
		.CHUNK_WORDS(CHUNK_WORDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.index       (index),
		.word        (word),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.dest_slot   (dest_slot),
		.write_enable(write_enable),
		.value       (value)
	);

	`ETVG_ASSERT_NEXT(a_gather_busy, start && !busy && opcode == etvg_pkg::OP_GATHER, busy, "gather did not raise busy")
	`ETVG_ASSERT_LATER(a_gather_done, start && !busy && opcode == etvg_pkg::OP_GATHER, done, "gather result missing")
	`ETVG_ASSERT_NOW(a_done_busy, done, busy, "result strobed while idle")
	`ETVG_ASSERT_NEXT(a_done_single, done, !done, "result strobed twice")

endmodule

// ----- sv/etvg_ram.sv -----
`timescale 1ns / 1ps

module etvg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/etvg_ctrl.sv -----
`timescale 1ns / 1ps

module etvg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              opcode,
	output logic              busy,
	output logic              done,
	output etvg_pkg::cmd_t    cmd
);

	etvg_pkg::state_t state_q;
	etvg_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= etvg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		busy        = 1'b1;
		done        = 1'b0;
		unique case (state_q)
			etvg_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (opcode == etvg_pkg::OP_GATHER) begin
						cmd.capture = 1'b1;
						state_d     = etvg_pkg::ST_LOOKUP;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			etvg_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = etvg_pkg::ST_RESP;
			end
			etvg_pkg::ST_RESP: begin
				cmd.respond = 1'b1;
				done        = 1'b1;
				state_d     = etvg_pkg::ST_IDLE;
			end
			default: begin
				state_d = etvg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/etvg_datapath.sv -----
`timescale 1ns / 1ps

module etvg_datapath #(
	parameter int CHUNK_WORDS = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  etvg_pkg::cmd_t                        cmd,
	input  logic [etvg_pkg::DATA_W-1:0]           index,
	input  logic [etvg_pkg::DATA_W-1:0]           word,
	input  logic                                  cfg_write,
	input  logic [etvg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [etvg_pkg::DATA_W-1:0]           cfg_data,
	output logic [etvg_pkg::POS_W-1:0]            dest_slot,
	output logic                                  write_enable,
	output logic [etvg_pkg::DATA_W-1:0]           value
);

	localparam int AW = $clog2(CHUNK_WORDS);
	localparam int SW = (AW + 1 > etvg_pkg::SIZE_W) ? AW + 1 : etvg_pkg::SIZE_W;
	localparam logic [SW-1:0] SIZE_LIM = SW'(CHUNK_WORDS);
	localparam logic [etvg_pkg::DATA_W-1:0] LOAD_LIM = etvg_pkg::DATA_W'(CHUNK_WORDS);

	logic [etvg_pkg::DATA_W-1:0] chunk_offset_q;
	logic [etvg_pkg::SIZE_W-1:0] chunk_size_q;
	logic                        face_layout_q;

	logic [etvg_pkg::DATA_W-1:0] index_q;
	logic [etvg_pkg::POS_W-1:0]  pos_q;
	logic                        row_ended_q;

	logic [etvg_pkg::POS_W-1:0]  dest_s2;
	logic                        we_s2;
	logic                        hit_s2;

	logic [SW-1:0]               size_ext;
	logic [SW-1:0]               size_eff;
	logic [etvg_pkg::DATA_W-1:0] diff;
	logic                        sentinel;
	logic                        hit;
	logic                        ended_now;
	logic                        ram_we;
	logic [etvg_pkg::DATA_W-1:0] rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_offset_q <= etvg_pkg::CHUNK_OFFSET_RESET;
			chunk_size_q   <= etvg_pkg::CHUNK_SIZE_RESET;
			face_layout_q  <= etvg_pkg::FACE_LAYOUT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				etvg_pkg::CFG_CHUNK_OFFSET: chunk_offset_q <= cfg_data;
				etvg_pkg::CFG_CHUNK_SIZE:   chunk_size_q   <= cfg_data[etvg_pkg::SIZE_W-1:0];
				etvg_pkg::CFG_FACE_LAYOUT:  face_layout_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// size saturates at the store depth
	assign size_ext = SW'(chunk_size_q);
	assign size_eff = (size_ext < SIZE_LIM) ? size_ext : SIZE_LIM;

	assign sentinel  = (index_q == etvg_pkg::SENTINEL);
	assign diff      = index_q - chunk_offset_q;
	assign hit       = !sentinel && (index_q >= chunk_offset_q)
		&& (diff < etvg_pkg::DATA_W'(size_eff));
	// the row-ended flag restarts at column zero
	assign ended_now = (row_ended_q && (pos_q[etvg_pkg::COL_W-1:0] != '0)) || sentinel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			row_ended_q <= 1'b0;
		end else if (cmd.lookup) begin
			pos_q       <= pos_q + 1'b1;
			row_ended_q <= ended_now;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			index_q <= index;
		if (cmd.lookup) begin
			dest_s2 <= etvg_pkg::dest_of(pos_q, face_layout_q);
			we_s2   <= ended_now || hit;
			hit_s2  <= !ended_now && hit;
		end
	end

	assign ram_we = cmd.load_wr && (index < LOAD_LIM);

	etvg_ram #(
		.WIDTH(etvg_pkg::DATA_W),
		.DEPTH(CHUNK_WORDS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(index[AW-1:0]),
		.wdata(word),
		.raddr(diff[AW-1:0]),
		.rdata(rdata)
	);

	assign dest_slot    = dest_s2;
	assign write_enable = we_s2;
	assign value        = (cmd.respond && hit_s2) ? rdata : '0;

endmodule

// ----- test/ellpack_tile_vector_gather_core_test.sv -----
`timescale 1ns / 1ps

module ellpack_tile_vector_gather_core_test;
	import etvg_pkg::*;

	localparam int STORE_WORDS = 1024;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0]  dest;
		logic              we;
		logic [DATA_W-1:0] val;
	} gather_result_t;

	// Mirrors the gather core: vector chunk store, tile walk, row-end flag,
	// chunk registers. Also holds the gathers still waiting for their result.
	class gather_tracker;
		logic [DATA_W-1:0] store [STORE_WORDS];
		bit                written [STORE_WORDS];
		logic [POS_W-1:0]  pos;
		bit                row_done;
		logic [DATA_W-1:0] offset;
		logic [SIZE_W-1:0] size_reg;
		bit                face;
		gather_result_t    pending [$];
		int                errors;

		function new();
			foreach (written[i])
				written[i] = 0;
			pos = '0;
			row_done = 0;
			offset = CHUNK_OFFSET_RESET;
			size_reg = CHUNK_SIZE_RESET;
			face = FACE_LAYOUT_RESET;
			errors = 0;
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10)
				$display("ERROR: %s", msg);
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] d);
			case (idx)
				CFG_CHUNK_OFFSET: offset = d;
				CFG_CHUNK_SIZE:   size_reg = d[SIZE_W-1:0];
				CFG_FACE_LAYOUT:  face = d[0];
				default: ;
			endcase
		endfunction

		// chunk length, saturated at the store depth
		function logic [32:0] span();
			return (size_reg > STORE_WORDS) ? 33'(STORE_WORDS) : 33'(size_reg);
		endfunction

		function bit in_chunk(logic [DATA_W-1:0] idx);
			logic [32:0] lo;
			lo = {1'b0, offset};
			return ({1'b0, idx} >= lo) && ({1'b0, idx} < lo + span());
		endfunction

		function void take_item(logic op, logic [DATA_W-1:0] idx, logic [DATA_W-1:0] wd);
			gather_result_t r;
			logic [COL_W-1:0] row;
			logic [COL_W-1:0] col;
			logic [DATA_W-1:0] slot;
			if (op == OP_LOAD) begin
				if (idx < STORE_WORDS) begin
					store[idx[9:0]] = wd;
					written[idx[9:0]] = 1;
				end
				return;
			end
			row = pos[POS_W-1:COL_W];
			col = pos[COL_W-1:0];
			if (col == 0)
				row_done = 0;
			r.we = 1'b0;
			r.val = '0;
			if (!row_done) begin
				if (idx == SENTINEL) begin
					row_done = 1;
				end else if (in_chunk(idx)) begin
					slot = idx - offset;
					r.val = store[slot[9:0]];
					r.we = 1'b1;
				end
			end
			if (row_done) begin
				r.we = 1'b1;
				r.val = '0;
			end
			r.dest = face ? {row[4], col[4], row[3:0], col[3:0]} : pos;
			pending.push_back(r);
			pos = pos + 1'b1;
		endfunction

		function void compare_result(logic [POS_W-1:0] d, logic w, logic [DATA_W-1:0] v);
			gather_result_t e;
			if (pending.size() == 0) begin
				note_error($sformatf("result with no gather pending: dest_slot=%0d", d));
				return;
			end
			e = pending.pop_front();
			if (d !== e.dest || w !== e.we || v !== e.val)
				note_error($sformatf(
					"dest_slot exp %0d got %0d, write_enable exp %b got %b, value exp %h got %h",
					e.dest, d, e.we, w, e.val, v));
		endfunction

		// highest store slot reachable as a hit (not shadowed by the sentinel)
		function int hit_limit();
			logic [32:0] lo;
			logic [32:0] top;
			lo = {1'b0, offset};
			if (span() == 0)
				return -1;
			top = lo + span() - 1;
			if (top > {1'b0, SENTINEL} - 1)
				top = {1'b0, SENTINEL} - 1;
			if (top < lo)
				return -1;
			return int'(top - lo);
		endfunction

		function logic [DATA_W-1:0] pick_miss();
			logic [32:0] hi;
			logic [DATA_W-1:0] c;
			hi = {1'b0, offset} + span();
			case ($urandom_range(2, 0))
				0: if (hi < {1'b0, SENTINEL})
					return hi[DATA_W-1:0];
				1: if (offset != 0)
					return offset - 1;
				default: ;
			endcase
			do
				c = $urandom();
			while (c == SENTINEL || in_chunk(c));
			return c;
		endfunction

		function logic [DATA_W-1:0] pick_hit();
			int lim;
			int s;
			lim = hit_limit();
			if (lim >= 0)
				repeat (12) begin
					s = $urandom_range(lim, 0);
					if (written[s])
						return offset + s;
				end
			return pick_miss();
		endfunction

		// any index, but never one that would read a slot not yet loaded
		function logic [DATA_W-1:0] pick_raw();
			logic [DATA_W-1:0] c;
			logic [DATA_W-1:0] s;
			c = $urandom();
			s = c - offset;
			if (c != SENTINEL && in_chunk(c) && !written[s[9:0]])
				return pick_miss();
			return c;
		endfunction

		function logic [DATA_W-1:0] load_slot();
			int lim;
			lim = hit_limit();
			case ($urandom_range(9, 0))
				0: return $urandom();
				1: return $urandom_range(STORE_WORDS - 1, 0);
				default: return (lim < 0) ? $urandom_range(STORE_WORDS - 1, 0)
					: $urandom_range(lim, 0);
			endcase
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic                   opcode;
	logic [DATA_W-1:0]      index;
	logic [DATA_W-1:0]      word;
	logic                   done;
	logic [POS_W-1:0]       dest_slot;
	logic                   write_enable;
	logic [DATA_W-1:0]      value;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [DATA_W-1:0]      cfg_data;

	gather_tracker tracker;
	int burst_left;
	int cycles = 0;

	ellpack_tile_vector_gather_core #(
		.CHUNK_WORDS(STORE_WORDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.index(index),
		.word(word),
		.done(done),
		.dest_slot(dest_slot),
		.write_enable(write_enable),
		.value(value),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.compare_result(dest_slot, write_enable, value);
	end

	// One item transfer; start stays high across a burst.
	task automatic send(logic op, logic [DATA_W-1:0] idx, logic [DATA_W-1:0] wd);
		int gap;
		start <= 1'b1;
		opcode <= op;
		index <= idx;
		word <= wd;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.take_item(op, idx, wd);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(24, 1);
			gap = $urandom_range(6, 0);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_put(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] d);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		tracker.set_reg(idx, d);
	endtask

	task automatic configure_chunk(logic [DATA_W-1:0] off, logic [SIZE_W-1:0] size,
		bit face, bit poke_unused);
		logic [DATA_W-1:0] junk;
		if (poke_unused)
			cfg_put(CFG_UNUSED, $urandom());
		cfg_put(CFG_CHUNK_OFFSET, off);
		junk = $urandom();
		cfg_put(CFG_CHUNK_SIZE, {junk[DATA_W-1:SIZE_W], size});
		junk = $urandom();
		cfg_put(CFG_FACE_LAYOUT, {junk[DATA_W-1:1], face});
		cfg_write <= 1'b0;
	endtask

	// Gathers up to the end of the current tile row, loads mixed in,
	// usually one sentinel somewhere in the row.
	task automatic run_row();
		int n;
		int end_col;
		logic [DATA_W-1:0] ix;
		repeat ($urandom_range(5, 0))
			send(OP_LOAD, tracker.load_slot(), $urandom());
		n = 32 - tracker.pos[COL_W-1:0];
		end_col = ($urandom_range(9, 0) < 6) ? $urandom_range(n - 1, 0) : -1;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9, 0) == 0)
				send(OP_LOAD, tracker.load_slot(), $urandom());
			if (i == end_col) begin
				ix = SENTINEL;
			end else begin
				case ($urandom_range(19, 0))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9: ix = tracker.pick_hit();
					10, 11, 12, 13, 14: ix = tracker.pick_miss();
					15, 16, 17, 18: ix = tracker.pick_raw();
					default: ix = SENTINEL;
				endcase
			end
			send(OP_GATHER, ix, $urandom());
		end
	endtask

	initial begin
		tracker = new();
		burst_left = $urandom_range(24, 1);
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= OP_LOAD;
		index <= '0;
		word <= '0;
		cfg_write <= 1'b0;
		cfg_index <= CFG_CHUNK_OFFSET;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset chunk: offset 0, full size, face layout
		send(OP_LOAD, 32'd0, 32'hFFFF_FFFF);
		send(OP_LOAD, 32'd1023, 32'h0000_0000);
		send(OP_LOAD, 32'd5, 32'hA5A5_A5A5);
		send(OP_LOAD, 32'd1, 32'h5A5A_5A5A);
		send(OP_LOAD, 32'd1024, $urandom());   // beyond the store: dropped
		send(OP_LOAD, SENTINEL, $urandom());
		send(OP_GATHER, 32'd0, $urandom());
		send(OP_GATHER, 32'd1023, $urandom());
		send(OP_GATHER, 32'd5, $urandom());
		send(OP_GATHER, 32'd1, $urandom());
		send(OP_GATHER, 32'd1024, $urandom());
		send(OP_GATHER, 32'hFFFF_FFFE, $urandom());
		send(OP_GATHER, SENTINEL, $urandom());
		send(OP_GATHER, 32'd0, $urandom());    // row already ended: zero
		send(OP_GATHER, 32'd1023, $urandom());
		send(OP_GATHER, SENTINEL, $urandom());
		run_row();

		// one or two rows per chunk setting
		for (int p = 0; p < 9; p++) begin
			drain();
			case (p)
				0: configure_chunk(32'd0, 11'd1, 1'b0, 1'b0);
				1: configure_chunk(32'hFFFF_FFFE, 11'd1024, 1'b1, 1'b0);
				2: configure_chunk($urandom_range(32'hFFFF_FFFE, 0),
					SIZE_W'($urandom_range(1024, 1)), 1'($urandom_range(1, 0)), 1'b0);
				3: configure_chunk($urandom_range(32'hFFFF_FFFE, 0), 11'd0,
					1'($urandom_range(1, 0)), 1'b0);
				4: configure_chunk($urandom_range(100, 0), 11'd2047, 1'b0, 1'b0);
				5: configure_chunk(32'd1000, 11'd24, 1'b1, 1'b0);
				6: configure_chunk($urandom_range(32'hFFFF_FFFE, 0),
					SIZE_W'($urandom_range(32, 1)), 1'($urandom_range(1, 0)), 1'b0);
				7: configure_chunk(32'd0, 11'd1024, 1'b1, 1'b0);
				default: configure_chunk($urandom_range(32'hFFFF_FFFE, 0),
					SIZE_W'($urandom_range(1024, 1)), 1'($urandom_range(1, 0)), 1'b1);
			endcase
			repeat ((p < 2) ? 2 : 1) run_row();
		end

		drain();
		repeat (10) @(posedge clk);
		if (tracker.pending.size() != 0)
			tracker.note_error($sformatf("%0d gathers never returned a result",
				tracker.pending.size()));
		if (tracker.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/etvg_pkg.sv
sv/etvg_ram.sv
sv/etvg_ctrl.sv
sv/etvg_datapath.sv
sv/ellpack_tile_vector_gather_core.sv
test/ellpack_tile_vector_gather_core_test.sv
